@@ rtl/scm_pkg.sv @@
// Shared types, constants and helpers for the subpixel coverage mask block.
// Imported by the front, queue, back and top level modules. No dependencies.
package scm_pkg;

  // Grid geometry
  localparam int unsigned PIXEL_WIDTH  = 64;
  localparam int unsigned PIXEL_HEIGHT = 64;
  localparam int unsigned SUB_X        = 8;
  localparam int unsigned SUB_Y        = 4;

  localparam int unsigned ROW_SUBPIXELS = PIXEL_WIDTH * SUB_X;
  localparam int unsigned COL_SUBPIXELS = PIXEL_HEIGHT * SUB_Y;
  localparam int unsigned CELLS         = SUB_X * SUB_Y;
  localparam int unsigned WORDS         = PIXEL_WIDTH * PIXEL_HEIGHT;

  localparam int unsigned ADDR_W = $clog2(WORDS);
  localparam int unsigned X_W    = $clog2(PIXEL_WIDTH);
  localparam int unsigned Y_W    = $clog2(PIXEL_HEIGHT);
  localparam int unsigned XL_W   = $clog2(SUB_X);
  localparam int unsigned YL_W   = $clog2(SUB_Y);

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned START_W = 9;
  localparam int unsigned END_W   = 10;
  localparam int unsigned PX_W    = 6;
  localparam int unsigned COV_W   = 6;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_SPAN   = 2'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [1:0] {
    CMD_SPAN,
    CMD_TOGGLE,
    CMD_READ,
    CMD_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [Y_W-1:0]    yh;
    logic [YL_W-1:0]   yl;
    logic [X_W-1:0]    x_first;
    logic [X_W-1:0]    x_last;
    logic [XL_W-1:0]   lo;
    logic [XL_W-1:0]   hi;
    logic              fill;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] word_addr(logic [Y_W-1:0] yh, logic [X_W-1:0] xh);
    return ADDR_W'(yh * PIXEL_WIDTH + xh);
  endfunction

  function automatic logic [COV_W-1:0] popcount(logic [CELLS-1:0] v);
    logic [COV_W-1:0] n;
    n = '0;
    for (int i = 0; i < CELLS; i++) begin
      n = n + COV_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ rtl/scm_front.sv @@
// Front end: classifies each accepted item into a queue command or drops it.
// Depends on scm_pkg.
module scm_front import scm_pkg::*; (
  input  logic               accept_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [ROW_W-1:0]   sub_row_i,
  input  logic [START_W-1:0] span_start_i,
  input  logic [END_W-1:0]   span_end_i,
  input  logic               fill_on_i,
  input  logic [PX_W-1:0]    pixel_x_i,
  input  logic [PX_W-1:0]    pixel_y_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [END_W-1:0] end_c;
  logic [END_W-1:0] end_m1;
  logic             row_ok;
  logic             col_ok;
  logic             span_empty;
  logic             pix_ok;
  logic             keep;

  always_comb begin
    // clamp the span end to the row
    end_c      = (32'(span_end_i) > ROW_SUBPIXELS) ? END_W'(ROW_SUBPIXELS) : span_end_i;
    end_m1     = end_c - END_W'(1);
    span_empty = end_c <= END_W'(span_start_i);
    row_ok     = 32'(sub_row_i) < COL_SUBPIXELS;
    col_ok     = 32'(span_start_i) < ROW_SUBPIXELS;
    pix_ok     = (32'(pixel_x_i) < PIXEL_WIDTH) && (32'(pixel_y_i) < PIXEL_HEIGHT);

    cmd_o.kind    = CMD_SPAN;
    cmd_o.yh      = Y_W'(sub_row_i / SUB_Y);
    cmd_o.yl      = YL_W'(sub_row_i % SUB_Y);
    cmd_o.x_first = X_W'(span_start_i / SUB_X);
    cmd_o.x_last  = X_W'(end_m1 / SUB_X);
    cmd_o.lo      = XL_W'(span_start_i % SUB_X);
    cmd_o.hi      = XL_W'(end_m1 % SUB_X);
    cmd_o.fill    = fill_on_i;
    keep          = 1'b0;

    unique case (operation_i)
      OP_SPAN: begin
        keep = row_ok && !span_empty;
      end
      OP_TOGGLE: begin
        cmd_o.kind   = CMD_TOGGLE;
        cmd_o.x_last = cmd_o.x_first;
        cmd_o.hi     = cmd_o.lo;
        keep         = row_ok && col_ok;
      end
      OP_READ: begin
        cmd_o.kind    = pix_ok ? CMD_READ : CMD_ZERO;
        cmd_o.yh      = Y_W'(pixel_y_i);
        cmd_o.x_first = X_W'(pixel_x_i);
        cmd_o.x_last  = X_W'(pixel_x_i);
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept_i && keep;

endmodule

@@ rtl/scm_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on scm_pkg for the command type and depth.
module scm_queue import scm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t               entry_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = count_q == Q_CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/scm_back.sv @@
// Back end: owns the coverage memory, runs the clearing pass after reset and
// executes queued commands by read-modify-write. Depends on scm_pkg.
module scm_back import scm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [COV_W-1:0] coverage_o,
  output logic             full_res_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_WR    = 2'd3;

  logic [CELLS-1:0]  mem [WORDS];
  logic [CELLS-1:0]  rdata_q;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  cmd_t              cmd_q, cmd_d;
  logic [X_W-1:0]    xh_q, xh_d;
  logic              out_valid_q, out_valid_d;
  logic [COV_W-1:0]  cov_q, cov_d;
  logic              full_q, full_d;

  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] raddr, waddr, cur_addr;
  logic [CELLS-1:0]  wdata;
  logic [XL_W-1:0]   lo_eff, hi_eff;
  logic [SUB_X-1:0]  row_mask;
  logic [CELLS-1:0]  cell_mask;
  logic [COV_W-1:0]  count;
  logic              head_ok;

  assign cur_addr = word_addr(cmd_q.yh, xh_q);
  assign count    = popcount(rdata_q);

  // Mask of the covered subpixels of the current word on the command's subrow
  always_comb begin
    lo_eff = (xh_q == cmd_q.x_first) ? cmd_q.lo : '0;
    hi_eff = (xh_q == cmd_q.x_last) ? cmd_q.hi : XL_W'(SUB_X - 1);
    for (int xl = 0; xl < SUB_X; xl++) begin
      row_mask[xl] = (XL_W'(xl) >= lo_eff) && (XL_W'(xl) <= hi_eff);
    end
    cell_mask = CELLS'(row_mask) << (32'(cmd_q.yl) * SUB_X);
  end

  // Reads need a free output register before they start
  assign head_ok = !empty_i &&
                   (((head_i.kind == CMD_SPAN) || (head_i.kind == CMD_TOGGLE)) || !out_valid_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    xh_d        = xh_q;
    out_valid_d = out_valid_q && out_stall_i;
    cov_d       = cov_q;
    full_d      = full_q;
    pop_o       = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    raddr       = cur_addr;
    waddr       = cur_addr;
    wdata       = rdata_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + ADDR_W'(1);
        if (32'(clr_q) == WORDS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_ok) begin
          pop_o = 1'b1;
          if (head_i.kind == CMD_ZERO) begin
            out_valid_d = 1'b1;
            cov_d       = '0;
            full_d      = 1'b0;
          end else begin
            mem_re  = 1'b1;
            raddr   = word_addr(head_i.yh, head_i.x_first);
            cmd_d   = head_i;
            xh_d    = head_i.x_first;
            state_d = ST_WR;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
        case (cmd_q.kind)
          CMD_SPAN: begin
            wdata = cmd_q.fill ? (rdata_q | cell_mask) : (rdata_q & ~cell_mask);
            if (xh_q != cmd_q.x_last) begin
              xh_d    = xh_q + X_W'(1);
              state_d = ST_RD;
            end
          end
          CMD_TOGGLE: begin
            wdata = rdata_q ^ cell_mask;
          end
          CMD_READ: begin
            wdata       = '0;
            out_valid_d = 1'b1;
            cov_d       = count;
            full_d      = 32'(count) == CELLS;
          end
          default: begin
            wdata = rdata_q;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    xh_q   <= xh_d;
    cov_q  <= cov_d;
    full_q <= full_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign clearing_o  = state_q == ST_CLEAR;
  assign out_valid_o = out_valid_q;
  assign coverage_o  = cov_q;
  assign full_res_o  = full_q;

endmodule

@@ rtl/subpixel_coverage_mask_core.sv @@
// Subpixel coverage mask: 64x64 pixels of 8x4 subpixel coverage words.
//
// Input channel (in_valid_i / in_stall_o) carries span writes, subpixel
// toggles and pixel reads; an item is taken when valid is high and stall low.
// Output channel (out_valid_o / out_stall_i) returns one coverage count and
// full flag per read; spans, toggles and unused codes return nothing.
// The front end classifies items into a two-entry command queue, so new
// items are taken while the back end works or a result waits, until the queue is full.
// Each command reads and writes back every pixel word it touches, one
// after the other (memory read, then write back), through the coverage
// memory; the first read goes out in the cycle that pops the command, and
// the next command is popped only after the last write back. A read result
// is registered from the write-back state; an off-grid read returns zero
// in the cycle after its pop. A read waits while a result is still held.
// After reset the block clears all 4096 words, one per cycle, and stalls the
// input while it clears. A stalled result stays on the outputs.
// Depends on scm_pkg, scm_front, scm_queue and scm_back.
module subpixel_coverage_mask_core import scm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [ROW_W-1:0]   sub_row_i,
  input  logic [START_W-1:0] span_start_i,
  input  logic [END_W-1:0]   span_end_i,
  input  logic               fill_on_i,
  input  logic [PX_W-1:0]    pixel_x_i,
  input  logic [PX_W-1:0]    pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COV_W-1:0]   coverage_o,
  output logic               full_res_o
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t head;
  logic clearing;

  assign in_stall_o = q_full || clearing;
  assign accept     = in_valid_i && !in_stall_o;

  scm_front u_front (
    .accept_i     (accept),
    .operation_i  (operation_i),
    .sub_row_i    (sub_row_i),
    .span_start_i (span_start_i),
    .span_end_i   (span_end_i),
    .fill_on_i    (fill_on_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  scm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty)
  );

  scm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .coverage_o  (coverage_o),
    .full_res_o  (full_res_o)
  );

endmodule

@@ rtl/scm_checker.sv @@
// Port-level checks for subpixel_coverage_mask_core, attached by bind.
// Depends on scm_pkg.
module scm_checker import scm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [COV_W-1:0] coverage_o,
  input logic             full_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(coverage_o) && $stable(full_res_o))
    else $error("stalled result changed");

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(coverage_o) <= CELLS)
    else $error("coverage count above subpixel count");

  a_full_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (full_res_o == (32'(coverage_o) == CELLS)))
    else $error("full flag disagrees with coverage count");

endmodule

bind subpixel_coverage_mask_core scm_checker u_scm_checker (.*);

@@ bench/tb_top.sv @@
// Testbench for subpixel_coverage_mask_core: span writes, toggles and pixel reads
// are checked against a behavioral copy of the coverage store kept in the bench.
// Depends on scm_pkg and the core RTL.
module tb_top;
  import scm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned DRAIN_CYCLES = 160;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
    logic               fill;
    logic [PX_W-1:0]    px;
    logic [PX_W-1:0]    py;
  } cov_item_t;

  typedef struct packed {
    logic [COV_W-1:0] count;
    logic             full;
  } pixel_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i  = '0;
  logic [ROW_W-1:0]   sub_row_i    = '0;
  logic [START_W-1:0] span_start_i = '0;
  logic [END_W-1:0]   span_end_i   = '0;
  logic               fill_on_i    = 1'b0;
  logic [PX_W-1:0]    pixel_x_i    = '0;
  logic [PX_W-1:0]    pixel_y_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [COV_W-1:0]   coverage_o;
  logic               full_res_o;

  cov_item_t     stim_items[$];
  pixel_result_t expected_reads[$];
  logic [CELLS-1:0] coverage_shadow [WORDS];

  cov_item_t   cur_item;
  int unsigned n_items;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_full_seen;
  int unsigned n_errors;
  int unsigned send_wait;
  int unsigned hold_left;
  bit          drv_calm;
  bit          mon_calm;

  subpixel_coverage_mask_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .sub_row_i    (sub_row_i),
    .span_start_i (span_start_i),
    .span_end_i   (span_end_i),
    .fill_on_i    (fill_on_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coverage_o   (coverage_o),
    .full_res_o   (full_res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic cov_item_t mk_item(input logic [OP_W-1:0] op, input int unsigned row,
                                        input int unsigned start, input int unsigned stop,
                                        input int unsigned fill, input int unsigned px,
                                        input int unsigned py);
    cov_item_t it;
    it.op    = op;
    it.row   = ROW_W'(row);
    it.start = START_W'(start);
    it.stop  = END_W'(stop);
    it.fill  = fill[0];
    it.px    = PX_W'(px);
    it.py    = PX_W'(py);
    return it;
  endfunction

  // Update the shadow store for one accepted item; queue the result of a read.
  task automatic apply_coverage_op(input cov_item_t it);
    int unsigned lim;
    int unsigned w;
    int unsigned b;
    int unsigned n;
    pixel_result_t res;
    case (it.op)
      OP_SPAN: begin
        if (it.row < COL_SUBPIXELS) begin
          lim = (it.stop > ROW_SUBPIXELS) ? ROW_SUBPIXELS : it.stop;
          for (int unsigned c = it.start; c < lim; c++) begin
            w = c / SUB_X + (it.row / SUB_Y) * PIXEL_WIDTH;
            b = c % SUB_X + (it.row % SUB_Y) * SUB_X;
            coverage_shadow[w][b] = it.fill;
          end
        end
      end
      OP_TOGGLE: begin
        if (it.row < COL_SUBPIXELS && it.start < ROW_SUBPIXELS) begin
          w = it.start / SUB_X + (it.row / SUB_Y) * PIXEL_WIDTH;
          b = it.start % SUB_X + (it.row % SUB_Y) * SUB_X;
          coverage_shadow[w][b] = ~coverage_shadow[w][b];
        end
      end
      OP_READ: begin
        res = '0;
        if (it.px < PIXEL_WIDTH && it.py < PIXEL_HEIGHT) begin
          w = it.px + it.py * PIXEL_WIDTH;
          n = 0;
          for (int unsigned i = 0; i < CELLS; i++) n += coverage_shadow[w][i];
          res.count = COV_W'(n);
          res.full  = (n == CELLS);
          coverage_shadow[w] = '0;
        end
        expected_reads.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Driver: present queued items, with a random gap before each one.
  always @(posedge clk_i or negedge rst_ni) begin
    cov_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
      foreach (coverage_shadow[i]) coverage_shadow[i] = '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_coverage_op(cur_item);
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait != 0) begin
          in_valid_i <= 1'b0;
          send_wait--;
        end else if (stim_items.size() != 0) begin
          nxt = stim_items.pop_front();
          cur_item = nxt;
          operation_i  <= nxt.op;
          sub_row_i    <= nxt.row;
          span_start_i <= nxt.start;
          span_end_i   <= nxt.stop;
          fill_on_i    <= nxt.fill;
          pixel_x_i    <= nxt.px;
          pixel_y_i    <= nxt.py;
          in_valid_i   <= 1'b1;
          if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
          send_wait = drv_calm ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each read result against the oldest expectation, then stall a while.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reads.size() == 0) begin
          flag_mismatch($sformatf("unexpected result coverage=%0d full=%0b",
                                  coverage_o, full_res_o));
        end else begin
          want = expected_reads.pop_front();
          n_checked++;
          if (want.full) n_full_seen++;
          if (coverage_o !== want.count || full_res_o !== want.full)
            flag_mismatch($sformatf("coverage exp %0d got %0d, full exp %0b got %0b",
                                    want.count, coverage_o, want.full, full_res_o));
        end
        if ($urandom_range(0, 49) == 0) mon_calm = !mon_calm;
        hold_left = mon_calm ? 0 : $urandom_range(0, 8);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned px0;
    int unsigned py0;
    int unsigned wpx;
    int unsigned lo;
    int unsigned hi;
    int unsigned s;
    int unsigned e;
    int unsigned r;
    logic [OP_W-1:0] op;

    // Directed: clamped row, full pixel, clears, empty spans, toggles, corners.
    stim_items.push_back(mk_item(OP_SPAN, 0, 0, 1023, 1, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++)
      stim_items.push_back(mk_item(OP_SPAN, 252 + i, 504, 512, 1, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 255, 511, 1023, 1, 63, 63));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 63, 63));
    stim_items.push_back(mk_item(OP_SPAN, 1, 0, 512, 1, 0, 0));
    stim_items.push_back(mk_item(OP_SPAN, 1, 8, 16, 0, 0, 0));
    stim_items.push_back(mk_item(OP_SPAN, 2, 100, 100, 1, 0, 0));
    stim_items.push_back(mk_item(OP_SPAN, 2, 300, 50, 1, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 1, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 12, 0));
    stim_items.push_back(mk_item(OP_TOGGLE, 255, 511, 0, 0, 0, 0));
    stim_items.push_back(mk_item(OP_TOGGLE, 255, 504, 0, 1, 0, 0));
    stim_items.push_back(mk_item(OP_TOGGLE, 255, 504, 0, 1, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 63, 63));
    stim_items.push_back(mk_item(OP_UNUSED, 255, 511, 1023, 1, 63, 63));
    stim_items.push_back(mk_item(OP_SPAN, 3, 511, 512, 1, 0, 0));
    stim_items.push_back(mk_item(OP_SPAN, 3, 0, 1, 0, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 63, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0, 0));
    stim_items.push_back(mk_item(OP_READ, 0, 0, 0, 0, 0, 63));

    // Random: mostly writes clustered on a few pixels then reads of them; some noise.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        px0 = $urandom_range(0, PIXEL_WIDTH - 1);
        py0 = $urandom_range(0, PIXEL_HEIGHT - 1);
        wpx = ($urandom_range(0, 39) == 0) ? PIXEL_WIDTH : $urandom_range(1, 3);
        if (px0 + wpx > PIXEL_WIDTH) wpx = PIXEL_WIDTH - px0;
        lo = px0 * SUB_X;
        hi = (px0 + wpx) * SUB_X;
        if ($urandom_range(0, 3) == 0) begin
          for (int i = 0; i < SUB_Y; i++) begin
            e = (hi == ROW_SUBPIXELS) ? $urandom_range(ROW_SUBPIXELS, 1023) : hi;
            stim_items.push_back(mk_item(OP_SPAN, py0 * SUB_Y + i, lo, e, 1,
                                         $urandom(), $urandom()));
            n_random++;
          end
        end
        repeat ($urandom_range(2, 6)) begin
          r = py0 * SUB_Y + $urandom_range(0, SUB_Y - 1);
          s = $urandom_range(lo, hi - 1);
          if ($urandom_range(0, 3) == 0) begin
            stim_items.push_back(mk_item(OP_TOGGLE, r, s, $urandom(), $urandom(),
                                         $urandom(), $urandom()));
          end else begin
            e = $urandom_range(s, hi);
            stim_items.push_back(mk_item(OP_SPAN, r, s, e, $urandom_range(0, 4) != 0,
                                         $urandom(), $urandom()));
          end
          n_random++;
        end
        for (int unsigned x = px0; x < px0 + wpx && x < px0 + 4; x++) begin
          stim_items.push_back(mk_item(OP_READ, $urandom(), $urandom(), $urandom(),
                                       $urandom(), x, py0));
          n_random++;
        end
      end else begin
        op = OP_W'($urandom_range(0, 3));
        stim_items.push_back(mk_item(op, $urandom_range(0, 255), $urandom_range(0, 511),
                                     $urandom_range(0, 1023), $urandom_range(0, 1),
                                     $urandom_range(0, 63), $urandom_range(0, 63)));
        if (op != OP_UNUSED) n_random++;
      end
    end
    n_items = stim_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items) @(posedge clk_i);
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items: %0d reads checked, %0d of them full pixels",
             n_items, n_checked, n_full_seen);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0 && expected_reads.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hold a generous bound on the whole run, clearing pass included.
  initial begin
    #3200000;
    $display("timeout: %0d of %0d items accepted, %0d results pending",
             n_accepted, n_items, expected_reads.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
